@@ sv/rhtc_pkg.sv @@
// shared types and constants of the rgb to hsv threshold classifier
package rhtc_pkg;

	// fixed-point scale factors
	localparam int unsigned HUE_SCALE = 3840;   // 60 degrees in 1/64 degree
	localparam int unsigned SAT_SCALE = 6400;   // 100 percent in 1/64 percent
	localparam int unsigned HUE_FULL  = 23040;  // 360 degrees in 1/64 degree

	// divider geometry: numerator width, quotient bits, one step per quotient bit
	localparam int unsigned NUM_W     = 23;
	localparam int unsigned QUO_W     = 15;
	localparam int unsigned DIV_STEPS = QUO_W;

	// hue numerator before scaling, at most five times the channel spread
	localparam int unsigned SPAN_W = 11;

	// decoupling queue between front and back, a power of two
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VAL_HIGH = 3'd5;

	// input pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// result of one pixel
	typedef struct packed {
		logic        keep;
		logic [14:0] hue;
		logic [12:0] saturation;
		logic [7:0]  brightness;
	} res_t;

	// threshold windows
	typedef struct packed {
		logic [14:0] hue_low;
		logic [14:0] hue_high;
		logic [12:0] sat_low;
		logic [12:0] sat_high;
		logic [7:0]  val_low;
		logic [7:0]  val_high;
	} cfg_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic [SPAN_W-1:0] span;   // hue numerator before scaling
		logic [7:0]        d;      // max minus min
		logic [7:0]        mx;     // largest channel
		logic              neg;    // red largest and blue above green
		logic              grey;   // all channels equal
	} item_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// one stage of the back's long-division pipeline
	typedef struct packed {
		logic [7:0]       h_rem;
		logic [QUO_W-1:0] h_num;
		logic [7:0]       s_rem;
		logic [QUO_W-1:0] s_num;
		logic [7:0]       d;
		logic [7:0]       mx;
		logic             neg;
		logic             grey;
	} div_t;

endpackage

@@ sv/rgb_hsv_threshold_classifier.sv @@
// top level of the rgb to hsv threshold classifier
// Converts one 8-bit RGB pixel per clock to hue (1/64 degree), saturation
// (1/64 percent) and value, and flags pixels whose hue, saturation and value
// all fall inside the programmed windows. Sustained rate is one pixel per
// cycle when nothing stalls; from input transfer to output valid a pixel
// passes the front register, the queue, the numerator stage, the
// 15-stage bit-per-stage divider that yields hue and saturation together and
// the hue fix-up stage, after which the output register offers the result.
// A four-entry queue sits between the front and the divider so either side
// can stall on its own.
// Write the window registers only while no pixel is in flight.
module rgb_hsv_threshold_classifier import rhtc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pix_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output res_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	logic    push, pop;
	item_t   push_data, head;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_low  <= 15'd5760;
			cfg_q.hue_high <= 15'd9600;
			cfg_q.sat_low  <= 13'd960;
			cfg_q.sat_high <= 13'd6400;
			cfg_q.val_low  <= 8'd25;
			cfg_q.val_high <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HUE_LOW: cfg_q.hue_low <= cfg_data[14:0];
				CFG_HUE_HIGH: cfg_q.hue_high <= cfg_data[14:0];
				CFG_SAT_LOW: cfg_q.sat_low <= cfg_data[12:0];
				CFG_SAT_HIGH: cfg_q.sat_high <= cfg_data[12:0];
				CFG_VAL_LOW: cfg_q.val_low <= cfg_data[7:0];
				CFG_VAL_HIGH: cfg_q.val_high <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	rhtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	rhtc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	rhtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ sv/rhtc_front.sv @@
// front end: takes pixels, finds max, min and hue sector, feeds the queue
module rhtc_front import rhtc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  pix_t    in_data,
	input  q_stat_t q_stat,
	output logic    push,
	output item_t   push_data
);

	logic       adv;
	logic [7:0] mx, mn, d;
	item_t      cls;
	logic       vld_s1;
	item_t      item_s1;

	// max and min, ties go to red then green
	always_comb begin
		mx = in_data.red;
		mn = in_data.red;
		if (in_data.green > mx) mx = in_data.green;
		if (in_data.blue > mx) mx = in_data.blue;
		if (in_data.green < mn) mn = in_data.green;
		if (in_data.blue < mn) mn = in_data.blue;
		d = mx - mn;
	end

	// hue sector and unscaled numerator
	always_comb begin
		cls.d    = d;
		cls.mx   = mx;
		cls.grey = (d == 8'd0);
		cls.neg  = 1'b0;
		if (mx == in_data.red) begin
			if (in_data.green >= in_data.blue) begin
				cls.span = SPAN_W'(in_data.green - in_data.blue);
			end else begin
				cls.span = SPAN_W'(in_data.blue - in_data.green);
				cls.neg  = 1'b1;
			end
		end else if (mx == in_data.green) begin
			cls.span = SPAN_W'(in_data.blue) + SPAN_W'({d, 1'b0}) - SPAN_W'(in_data.red);
		end else begin
			cls.span = SPAN_W'(in_data.red) + SPAN_W'({d, 2'b00}) - SPAN_W'(in_data.green);
		end
	end

	// stage moves when empty or when the queue takes its item
	assign adv       = !vld_s1 || !q_stat.full;
	assign in_stall  = !adv;
	assign push      = vld_s1 && !q_stat.full;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

@@ sv/rhtc_queue.sv @@
// short fifo that decouples the front from the back
module rhtc_queue import rhtc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_data,
	input  logic    pop,
	output item_t   head,
	output q_stat_t stat
);

	item_t            fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = fifo_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/rhtc_back.sv @@
// back end: scales, divides one bit per stage, fixes hue, tests windows
module rhtc_back import rhtc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  item_t   head,
	output logic    pop,
	input  cfg_t    cfg,
	output logic    out_valid,
	input  logic    out_stall,
	output res_t    out_data
);

	logic            en;
	logic [NUM_W-1:0] h_n, s_n;
	div_t            stage_in;
	div_t            div_s [DIV_STEPS+1];
	logic            dvld_s [DIV_STEPS+1];
	logic            fix_vld_s;
	logic [14:0]     fix_hue_s;
	logic [12:0]     fix_sat_s;
	logic [7:0]      fix_val_s;
	logic            hue_ok, keep;
	logic            out_valid_q;
	res_t            out_q;

	// one restoring step for both quotients
	function automatic div_t div_step(div_t c);
		div_t       n;
		logic [8:0] th, ts;
		n  = c;
		th = {c.h_rem, c.h_num[QUO_W-1]};
		ts = {c.s_rem, c.s_num[QUO_W-1]};
		if (th >= {1'b0, c.d}) begin
			n.h_rem = 8'(th - {1'b0, c.d});
			n.h_num = {c.h_num[QUO_W-2:0], 1'b1};
		end else begin
			n.h_rem = th[7:0];
			n.h_num = {c.h_num[QUO_W-2:0], 1'b0};
		end
		if (ts >= {1'b0, c.mx}) begin
			n.s_rem = 8'(ts - {1'b0, c.mx});
			n.s_num = {c.s_num[QUO_W-2:0], 1'b1};
		end else begin
			n.s_rem = ts[7:0];
			n.s_num = {c.s_num[QUO_W-2:0], 1'b0};
		end
		return n;
	endfunction

	// whole pipeline moves when the output slot frees
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !q_stat.empty;

	// scale numerators; the top bits already lie below the divisor
	always_comb begin
		h_n = NUM_W'(head.span) * NUM_W'(HUE_SCALE);
		s_n = NUM_W'(head.d) * NUM_W'(SAT_SCALE);
		stage_in.h_rem = h_n[NUM_W-1:QUO_W];
		stage_in.h_num = h_n[QUO_W-1:0];
		stage_in.s_rem = s_n[NUM_W-1:QUO_W];
		stage_in.s_num = s_n[QUO_W-1:0];
		stage_in.d     = head.d;
		stage_in.mx    = head.mx;
		stage_in.neg   = head.neg;
		stage_in.grey  = head.grey;
	end

	// valid bits of the divider line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++) dvld_s[i] <= 1'b0;
			fix_vld_s   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			dvld_s[0] <= pop;
			for (int i = 1; i <= DIV_STEPS; i++) dvld_s[i] <= dvld_s[i-1];
			fix_vld_s   <= dvld_s[DIV_STEPS];
			out_valid_q <= fix_vld_s;
		end
	end

	// divider payload, one quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= stage_in;
			for (int i = 1; i <= DIV_STEPS; i++) div_s[i] <= div_step(div_s[i-1]);
		end
	end

	// hue wrap for negative red sector, grey forces zero
	always_ff @(posedge clk) begin
		if (en) begin
			fix_val_s <= div_s[DIV_STEPS].mx;
			if (div_s[DIV_STEPS].grey) begin
				fix_hue_s <= '0;
				fix_sat_s <= '0;
			end else begin
				fix_sat_s <= div_s[DIV_STEPS].s_num[12:0];
				if (div_s[DIV_STEPS].neg && (div_s[DIV_STEPS].h_num != '0)) begin
					fix_hue_s <= 15'(HUE_FULL) - div_s[DIV_STEPS].h_num;
				end else begin
					fix_hue_s <= div_s[DIV_STEPS].h_num;
				end
			end
		end
	end

	// window tests, hue window wraps when low is not below high
	always_comb begin
		if (cfg.hue_low < cfg.hue_high) begin
			hue_ok = (cfg.hue_low <= fix_hue_s) && (fix_hue_s <= cfg.hue_high);
		end else begin
			hue_ok = (cfg.hue_low <= fix_hue_s) || (fix_hue_s <= cfg.hue_high);
		end
		keep = hue_ok && (cfg.sat_low <= fix_sat_s) && (fix_sat_s <= cfg.sat_high)
			&& (cfg.val_low <= fix_val_s) && (fix_val_s <= cfg.val_high);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.keep       <= keep;
			out_q.hue        <= fix_hue_s;
			out_q.saturation <= fix_sat_s;
			out_q.brightness <= fix_val_s;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/rhtc_checker.sv @@
// port-level checks of the classifier and their binding to the top level
module rhtc_checker import rhtc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input res_t out_data
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result changed while stalled");

	// zero saturation only comes from grey pixels, which have zero hue
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.saturation == 13'd0) |-> (out_data.hue == 15'd0))
		else $error("zero saturation with nonzero hue");

	// hue and saturation stay inside their ranges
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.hue < 15'(HUE_FULL)) &&
			(out_data.saturation <= 13'(SAT_SCALE)))
		else $error("hue or saturation out of range");

endmodule

bind rgb_hsv_threshold_classifier rhtc_checker u_rhtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

@@ tb/sv/hsv_result_checker.sv @@
// result checker: predicts each pixel's hsv classification and compares the output
module hsv_result_checker import rhtc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  pix_t                 in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  res_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int unsigned          in_flight,
	output int unsigned          errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REPORT_MAX = 10;

	// window registers as they come out of reset
	localparam cfg_t WIN_RESET = '{
		hue_low:  15'd5760,
		hue_high: 15'd9600,
		sat_low:  13'd960,
		sat_high: 13'd6400,
		val_low:  8'd25,
		val_high: 8'd255
	};

	cfg_t win;
	res_t classified_q [$];
	res_t want;

	// hsv conversion and window test of one pixel
	function automatic res_t hsv_classify(input pix_t p, input cfg_t w);
		int unsigned r, g, b, mx, mn, d, h, s;
		logic        hue_ok;
		res_t        res;
		r  = p.red;
		g  = p.green;
		b  = p.blue;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d  = mx - mn;
		if (d == 0) begin
			h = 0;
			s = 0;
		end else begin
			// red wins ties for max, then green
			if (mx == r) begin
				if (g >= b) begin
					h = HUE_SCALE * (g - b) / d;
				end else begin
					// negative hue, truncated toward zero then wrapped by 360 degrees
					h = HUE_SCALE * (b - g) / d;
					if (h != 0) h = HUE_FULL - h;
				end
			end else if (mx == g) begin
				h = HUE_SCALE * (b + 2 * d - r) / d;
			end else begin
				h = HUE_SCALE * (r + 4 * d - g) / d;
			end
			s = SAT_SCALE * d / mx;
		end
		// hue window wraps when low is not below high
		if (w.hue_low < w.hue_high)
			hue_ok = (w.hue_low <= h) && (h <= w.hue_high);
		else
			hue_ok = (w.hue_low <= h) || (h <= w.hue_high);
		res.keep       = hue_ok && (w.sat_low <= s) && (s <= w.sat_high) &&
			(w.val_low <= mx) && (mx <= w.val_high);
		res.hue        = h[14:0];
		res.saturation = s[12:0];
		res.brightness = mx[7:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win <= WIN_RESET;
			classified_q.delete();
			in_flight <= 0;
			errors    <= 0;
		end else begin
			// mirror of the window registers
			if (cfg_we) begin
				case (cfg_index)
					CFG_HUE_LOW:  win.hue_low  <= cfg_data;
					CFG_HUE_HIGH: win.hue_high <= cfg_data;
					CFG_SAT_LOW:  win.sat_low  <= cfg_data[12:0];
					CFG_SAT_HIGH: win.sat_high <= cfg_data[12:0];
					CFG_VAL_LOW:  win.val_low  <= cfg_data[7:0];
					CFG_VAL_HIGH: win.val_high <= cfg_data[7:0];
					default: ;
				endcase
			end
			// result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				if (classified_q.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("%t unexpected result keep/hue/sat/val %0b/%0d/%0d/%0d",
							$time, out_data.keep, out_data.hue, out_data.saturation,
							out_data.brightness);
					errors <= errors + 1;
				end else begin
					want = classified_q.pop_front();
					if (out_data.keep !== want.keep || out_data.hue !== want.hue ||
						out_data.saturation !== want.saturation ||
						out_data.brightness !== want.brightness) begin
						if (errors < REPORT_MAX)
							$display("%t keep/hue/sat/val exp %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
								$time, want.keep, want.hue, want.saturation,
								want.brightness, out_data.keep, out_data.hue,
								out_data.saturation, out_data.brightness);
						errors <= errors + 1;
					end
				end
			end
			// prediction for each pixel transfer
			if (in_valid && !in_stall)
				classified_q.push_back(hsv_classify(in_data, win));
			in_flight <= classified_q.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench top: drives pixels and window settings into the classifier and gives the verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rhtc_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned PHASE_PIXELS = 216;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	pix_t                 in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	res_t                 out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	int unsigned          in_flight;
	int unsigned          errors;
	int unsigned          cycles     = 0;
	int unsigned          gap_odds   = 0;
	int unsigned          stall_odds = 0;

	rgb_hsv_threshold_classifier i_dut (.*);

	hsv_result_checker i_checker (.*);

	always #1 clk = ~clk;

	// cycle limit
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver stalls in random bursts
	always begin
		@(posedge clk);
		if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	// one pixel transfer, then maybe a burst of idle cycles
	task automatic send_pixel(input pix_t p);
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (in_stall);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// wait until every predicted result has come out and the pipe is quiet
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// all six windows back to back, plus writes to the unmapped indexes
	task automatic program_windows(input logic [CFG_DAT_W-1:0] hue_lo, hue_hi,
		sat_lo, sat_hi, val_lo, val_hi);
		write_reg(CFG_HUE_LOW, hue_lo);
		write_reg(CFG_HUE_HIGH, hue_hi);
		write_reg(CFG_SAT_LOW, sat_lo);
		write_reg(CFG_SAT_HIGH, sat_hi);
		write_reg(CFG_VAL_LOW, val_lo);
		write_reg(CFG_VAL_HIGH, val_hi);
		write_reg(CFG_VAL_HIGH + 3'd1, CFG_DAT_W'($urandom));
		write_reg(CFG_VAL_HIGH + 3'd2, CFG_DAT_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// random in-range windows; hue order left free so it may wrap
	task automatic program_random_windows();
		int unsigned s0, s1, v0, v1;
		s0 = $urandom_range(0, SAT_SCALE);
		s1 = $urandom_range(0, SAT_SCALE);
		v0 = $urandom_range(0, 255);
		v1 = $urandom_range(0, 255);
		program_windows(CFG_DAT_W'($urandom_range(0, HUE_FULL - 1)),
			CFG_DAT_W'($urandom_range(0, HUE_FULL - 1)),
			CFG_DAT_W'((s0 < s1) ? s0 : s1), CFG_DAT_W'((s0 < s1) ? s1 : s0),
			CFG_DAT_W'((v0 < v1) ? v0 : v1), CFG_DAT_W'((v0 < v1) ? v1 : v0));
	endtask

	// one of 0, 1, 254, 255
	function automatic logic [7:0] edge_level();
		logic [1:0] pick;
		pick = 2'($urandom_range(0, 3));
		return {{7{pick[1]}}, pick[0]};
	endfunction

	// random pixel, weighted toward greys, ties and channel extremes
	function automatic pix_t rand_pixel();
		pix_t       p;
		logic [7:0] hi_lvl, lo_lvl;
		p      = 24'($urandom_range(0, 24'hFF_FFFF));
		hi_lvl = 8'($urandom_range(0, 255));
		lo_lvl = 8'($urandom_range(0, hi_lvl));
		case ($urandom_range(0, 11))
			0: p = {hi_lvl, hi_lvl, hi_lvl};
			1: p = {hi_lvl, hi_lvl, lo_lvl};
			2: p = {lo_lvl, hi_lvl, hi_lvl};
			3: p = {hi_lvl, lo_lvl, hi_lvl};
			4: p = {lo_lvl, hi_lvl, lo_lvl};
			5: p = {edge_level(), edge_level(), edge_level()};
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		logic [23:0] corners [$];
		// greys, primaries, max ties, hue wrap, tiny spread and window edges
		corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
			24'h010000, 24'h808080, 24'h191919, 24'h181818, 24'h0A141E,
			24'hC86432, 24'h01FEFF, 24'h64C800, 24'h00C864, 24'hAAC8B9,
			24'hFE01FF};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset windows first
		gap_odds   = 4;
		stall_odds = 4;
		foreach (corners[i])
			send_pixel(corners[i]);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				// hue window wraps through zero
				0: program_windows(15'd20000, 15'd3000, 15'd0, 15'd6400, 15'd0, 15'd255);
				// widest in-range windows
				1: program_windows(15'd0, 15'd23039, 15'd0, 15'd6400, 15'd0, 15'd255);
				// all-zero hue bounds, saturation and value pinned to the top
				2: program_windows(15'd0, 15'd0, 15'd6400, 15'd6400, 15'd255, 15'd255);
				// empty saturation and value windows
				3: program_windows(15'd23039, 15'd23039, 15'd5000, 15'd100, 15'd200, 15'd10);
				// all-ones data, bounds past their stated range
				4: program_windows(15'h7FFF, 15'h7FFF, 15'd0, 15'h7FFF, 15'd0, 15'h7FFF);
				6: program_windows(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
					CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
					CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
				default: program_random_windows();
			endcase
			gap_odds   = (phase == 3 || phase == PHASES - 1) ? 0 : 4;
			stall_odds = (phase == 5 || phase == PHASES - 1) ? 0 : 4;
			repeat (PHASE_PIXELS)
				send_pixel(rand_pixel());
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
